### sv/gscc_pkg.sv
// ----------------------------------------------------------------------------
// gscc_pkg: shared definitions for the gated short causal convolution
// Sizes, field widths, command and register codes, and the item and result
// structures that pass between the top level and the convolution engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gscc_pkg;

	// Storage geometry
	localparam int CHANNELS   = 256;
	localparam int TAPS       = 4;
	localparam int SLOTS      = 4;
	localparam int HIST_DEPTH = TAPS - 1;

	// Fixed field widths
	localparam int DATA_W = 16;
	localparam int SLOT_W = 2;
	localparam int CH_W   = 8;
	localparam int TAP_FW = 2;
	localparam int CFG_W  = 3;

	// Internal widths
	localparam int TAP_W   = $clog2(TAPS);
	localparam int TCNT_W  = $clog2(TAPS + 1);
	localparam int HIDX_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int WADDR_W = $clog2(CHANNELS * TAPS);
	localparam int HROWS   = SLOTS * CHANNELS;
	localparam int HROW_W  = (HROWS > 1) ? $clog2(HROWS) : 1;
	localparam int ROW_W   = HIST_DEPTH * DATA_W;
	localparam int CONV_W  = 2 * DATA_W + TAP_W;
	localparam int GP_W    = DATA_W + CONV_W;

	// Fixed-point scaling: p is Q4.12 * Q4.12, y is Q4.12 * Q8.24
	localparam int P_SHIFT = 12;
	localparam int Y_SHIFT = 24;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_TAPS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] TAPS_RESET = CFG_W'(3);

	// Item commands
	localparam logic CMD_DATA   = 1'b0;
	localparam logic CMD_WEIGHT = 1'b1;

	typedef logic [HIST_DEPTH-1:0][DATA_W-1:0] hrow_t;

	typedef struct packed {
		logic                     cmd;
		logic [SLOT_W-1:0]        slot;
		logic [CH_W-1:0]          channel;
		logic [TAP_FW-1:0]        tap;
		logic                     start_req;
		logic signed [DATA_W-1:0] gate_b;
		logic signed [DATA_W-1:0] gate_c;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] weight_value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] y;
		logic [SLOT_W-1:0]        slot;
		logic [CH_W-1:0]          channel;
		logic                     saturated;
	} result_t;

endpackage

`default_nettype wire

### sv/gated_short_causal_conv_top.sv
// ----------------------------------------------------------------------------
// gated_short_causal_conv_top: gated depthwise causal convolution block
// Configuration register, input item packing, result register and checks
// around the memory-based convolution engine.
// ----------------------------------------------------------------------------
// Each data item carries one channel sample of one token for one stream slot.
// The block forms p = gate_b * x in Q4.12 (rounded half up, clipped), takes a
// causal convolution over p and the earlier p values of that slot and channel
// using taps_in_use per-channel weights, the highest used tap weighting the
// newest p, and returns y = gate_c * conv, rounded and clipped, with a flag
// that is set whenever p or y was clipped. A start_req item reads its history
// as zeros. Weight items (cmd set) load one tap weight and give no result;
// every weight that a data item will use must be written first. Weights and
// history live in two synchronous memories; the history row of the slot and
// channel is read once, shifted and written back before the taps are summed
// through one multiply-accumulate unit fed by the weight memory, one tap per
// cycle. A data item passes through a product step, one accumulate step per
// used tap, a gate step and a done step that waits for the output register,
// while a weight item leaves the engine idle. The finished result sits
// in an output register, so the next item is taken while it waits. After
// reset the history memory is cleared row by row, 1024 rows in all
// (SLOTS * CHANNELS), during which no item is accepted; the configuration
// port works throughout. taps_in_use sits at byte address 0 and resets to 3;
// a value of 0 behaves as 1 and a value above 4 as 4. Change it only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_short_causal_conv_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [gscc_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [gscc_pkg::PDATA_W-1:0]       pwdata,
	output logic      [gscc_pkg::PDATA_W-1:0]       prdata,
	output logic                                    pready,
	// Input items
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               cmd,
	input  wire logic [gscc_pkg::SLOT_W-1:0]        slot,
	input  wire logic [gscc_pkg::CH_W-1:0]          channel,
	input  wire logic [gscc_pkg::TAP_FW-1:0]        tap,
	input  wire logic                               start_req,
	input  wire logic signed [gscc_pkg::DATA_W-1:0] gate_b,
	input  wire logic signed [gscc_pkg::DATA_W-1:0] gate_c,
	input  wire logic signed [gscc_pkg::DATA_W-1:0] x,
	input  wire logic signed [gscc_pkg::DATA_W-1:0] weight_value,
	// Result items
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [gscc_pkg::DATA_W-1:0]      y,
	output logic [gscc_pkg::SLOT_W-1:0]             out_slot,
	output logic [gscc_pkg::CH_W-1:0]               out_channel,
	output logic                                    saturated
);
	import gscc_pkg::*;

	logic [CFG_W-1:0] taps_q;
	logic             cfg_wr;
	logic             reg_sel;

	item_t   item;
	result_t res;
	logic    res_valid;
	logic    res_ready;

	logic    out_valid_q;
	result_t out_q;

	// The register index is the word address above the byte offset.
	assign pready  = 1'b1;
	assign reg_sel = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= TAPS_RESET;
		end else if (cfg_wr && (reg_sel == REG_TAPS_IN_USE)) begin
			taps_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_TAPS_IN_USE) ? PDATA_W'(taps_q) : '0;

	assign item.cmd          = cmd;
	assign item.slot         = slot;
	assign item.channel      = channel;
	assign item.tap          = tap;
	assign item.start_req    = start_req;
	assign item.gate_b       = gate_b;
	assign item.gate_c       = gate_c;
	assign item.x            = x;
	assign item.weight_value = weight_value;

	gscc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.item        (item),
		.taps_in_use (taps_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Output register: the engine hands over a result whenever the register
	// is empty or its item is being taken in the same cycle.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign y           = out_q.y;
	assign out_slot    = out_q.slot;
	assign out_channel = out_q.channel;
	assign saturated   = out_q.saturated;

	// The engine works on one item at a time, so it never offers a result
	// while it is free to take a new item.
	a_engine_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && res_valid))
		else $error("engine offers a result while accepting items");

	// A weight item leaves the engine idle and produces no result.
	a_weight_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_WEIGHT)) |=> (!res_valid && in_ready))
		else $error("weight item produced a result or occupied the engine");

	// A write to an address beyond the register list leaves taps_in_use alone.
	a_cfg_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && (reg_sel != REG_TAPS_IN_USE)) |=> $stable(taps_q))
		else $error("write to an unused address changed taps_in_use");

endmodule

`default_nettype wire

### sv/gscc_ram.sv
// ----------------------------------------------------------------------------
// gscc_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gscc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/gscc_engine.sv
// ----------------------------------------------------------------------------
// gscc_engine: sequencer and datapath of the gated causal convolution
// Holds the weight and history memories, forms the gated input, runs one
// multiply-accumulate per tap and applies the output gate.
// ----------------------------------------------------------------------------
`default_nettype none

module gscc_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire gscc_pkg::item_t            item,
	input  wire logic [gscc_pkg::CFG_W-1:0] taps_in_use,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output gscc_pkg::result_t               res
);
	import gscc_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_PROD  = 6'b000100,
		S_MAC   = 6'b001000,
		S_GATE  = 6'b010000,
		S_DONE  = 6'b100000
	} eng_state_t;

	localparam int PS_W = 2 * DATA_W + 1 - P_SHIFT;
	localparam int YS_W = GP_W + 1 - Y_SHIFT;

	eng_state_t state_q;
	logic [HROW_W-1:0] clr_q;

	// Per-item registers
	logic [SLOT_W-1:0]         slot_q;
	logic [CH_W-1:0]           ch_q;
	logic                      start_q;
	logic signed [DATA_W-1:0]  gb_q;
	logic signed [DATA_W-1:0]  gc_q;
	logic signed [DATA_W-1:0]  x_q;
	logic [TCNT_W-1:0]         n_q;
	logic signed [DATA_W-1:0]  p_q;
	logic                      clip_q;
	hrow_t                     hist_q;
	logic [TAP_W-1:0]          k_q;
	logic signed [CONV_W-1:0]  acc_q;
	logic signed [GP_W-1:0]    gprod_q;

	// Memory ports
	logic               w_we;
	logic [WADDR_W-1:0] w_waddr;
	logic [WADDR_W-1:0] w_raddr;
	logic [DATA_W-1:0]  w_rdata;
	logic               h_we;
	logic [HROW_W-1:0]  h_waddr;
	hrow_t              h_wdata;
	logic [HROW_W-1:0]  h_raddr;
	hrow_t              h_rdata;

	logic              accept;
	logic              ch_ok;
	logic              slot_ok;
	logic              tap_ok;
	logic              data_go;
	logic [TCNT_W-1:0] n_eff;
	logic [TAP_W-1:0]  k_rd;

	logic signed [2*DATA_W-1:0] p_prod;
	logic signed [2*DATA_W:0]   p_bias;
	logic signed [PS_W-1:0]     p_shr;
	logic [PS_W-DATA_W:0]       p_hi;
	logic signed [DATA_W-1:0]   p_sat;
	logic                       p_clip;
	hrow_t                      hist_row;
	hrow_t                      new_row;

	logic                       mac_last;
	logic [HIDX_W-1:0]          h_idx;
	logic signed [DATA_W-1:0]   mac_op;
	logic signed [2*DATA_W-1:0] mac_prod;

	logic signed [GP_W:0]     y_bias;
	logic signed [YS_W-1:0]   y_shr;
	logic [YS_W-DATA_W:0]     y_hi;
	logic signed [DATA_W-1:0] y_sat;
	logic                     y_clip;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign ch_ok    = (int'(item.channel) < CHANNELS);
	assign slot_ok  = (int'(item.slot) < SLOTS);
	assign tap_ok   = (int'(item.tap) < TAPS);
	assign data_go  = accept && (item.cmd == CMD_DATA) && ch_ok && slot_ok;

	// Out-of-range tap counts fall back to the nearest legal count.
	always_comb begin
		if (taps_in_use == '0) begin
			n_eff = TCNT_W'(1);
		end else if (int'(taps_in_use) > TAPS) begin
			n_eff = TCNT_W'(TAPS);
		end else begin
			n_eff = TCNT_W'(taps_in_use);
		end
	end

	// Weight memory: entry channel*TAPS+tap.
	assign w_we    = accept && (item.cmd == CMD_WEIGHT) && ch_ok && tap_ok;
	assign w_waddr = WADDR_W'(item.channel) * WADDR_W'(TAPS) + WADDR_W'(item.tap);
	assign k_rd    = (state_q == S_MAC) ? TAP_W'(k_q + 1'b1) : '0;
	assign w_raddr = WADDR_W'(ch_q) * WADDR_W'(TAPS) + WADDR_W'(k_rd);

	gscc_ram #(
		.DEPTH (CHANNELS * TAPS),
		.WIDTH (DATA_W)
	) u_wgt_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (item.weight_value),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// History memory: one row of ages 1..TAPS-1 per slot and channel.
	assign h_raddr = HROW_W'(item.slot) * HROW_W'(CHANNELS) + HROW_W'(item.channel);
	assign h_we    = (state_q == S_CLEAR) || (state_q == S_PROD);
	assign h_waddr = (state_q == S_CLEAR) ? clr_q
		: HROW_W'(slot_q) * HROW_W'(CHANNELS) + HROW_W'(ch_q);
	assign h_wdata = (state_q == S_CLEAR) ? '0 : new_row;

	gscc_ram #(
		.DEPTH (HROWS),
		.WIDTH (ROW_W)
	) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	// Gated input, rounded half up and clipped to 16 bits.
	always_comb begin
		p_prod = gb_q * x_q;
		p_bias = (2*DATA_W+1)'(p_prod) + (2*DATA_W+1)'(1 << (P_SHIFT - 1));
		p_shr  = PS_W'(p_bias >>> P_SHIFT);
		p_hi   = p_shr[PS_W-1:DATA_W-1];
		p_clip = !((&p_hi) || !(|p_hi));
		if (!p_clip) begin
			p_sat = p_shr[DATA_W-1:0];
		end else if (p_shr[PS_W-1]) begin
			p_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			p_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		hist_row = start_q ? '0 : h_rdata;
		new_row[0] = p_sat;
		for (int a = 1; a < HIST_DEPTH; a++) begin
			new_row[a] = hist_row[a-1];
		end
	end

	// Tap k weights p when it is the last used tap, else the p of age n-1-k.
	always_comb begin
		mac_last = ((TCNT_W'(k_q) + TCNT_W'(1)) == n_q);
		h_idx    = HIDX_W'(n_q - TCNT_W'(2) - TCNT_W'(k_q));
		mac_op   = mac_last ? p_q : $signed(hist_q[h_idx]);
		mac_prod = mac_op * $signed(w_rdata);
	end

	// Output gate, rounded half up and clipped.
	always_comb begin
		y_bias = (GP_W+1)'(gprod_q) + (GP_W+1)'(1 << (Y_SHIFT - 1));
		y_shr  = YS_W'(y_bias >>> Y_SHIFT);
		y_hi   = y_shr[YS_W-1:DATA_W-1];
		y_clip = !((&y_hi) || !(|y_hi));
		if (!y_clip) begin
			y_sat = y_shr[DATA_W-1:0];
		end else if (y_shr[YS_W-1]) begin
			y_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	assign res_valid     = (state_q == S_DONE);
	assign res.y         = y_sat;
	assign res.slot      = slot_q;
	assign res.channel   = ch_q;
	assign res.saturated = clip_q || y_clip;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= HROW_W'(clr_q + 1'b1);
					if (clr_q == HROW_W'(HROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (data_go) begin
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (mac_last) begin
						state_q <= S_GATE;
					end
				end
				S_GATE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (data_go) begin
			slot_q  <= item.slot;
			ch_q    <= item.channel;
			start_q <= item.start_req;
			gb_q    <= item.gate_b;
			gc_q    <= item.gate_c;
			x_q     <= item.x;
			n_q     <= n_eff;
		end
		if (state_q == S_PROD) begin
			p_q    <= p_sat;
			clip_q <= p_clip;
			hist_q <= hist_row;
			k_q    <= '0;
			acc_q  <= '0;
		end
		if (state_q == S_MAC) begin
			acc_q <= acc_q + CONV_W'(mac_prod);
			k_q   <= TAP_W'(k_q + 1'b1);
		end
		if (state_q == S_GATE) begin
			gprod_q <= gc_q * acc_q;
		end
	end

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for gated_short_causal_conv_top
// Loads tap weights and sends data items with random idling on both the
// item and result channels, while a bit-accurate tracker keeps its own copy
// of the weights, the gated histories and taps_in_use and predicts each
// result. Results are checked in order, field by field, and taps_in_use is
// stepped through its whole range between phases.
// ----------------------------------------------------------------------------

// Tracks weights, per-stream history and the tap count, predicts one result
// per data item and checks the results in arrival order.
class gated_conv_tracker;
	typedef gscc_pkg::item_t   item_t;
	typedef gscc_pkg::result_t result_t;
	typedef logic signed [gscc_pkg::DATA_W-1:0] q_t;

	logic [gscc_pkg::CFG_W-1:0] taps_reg;
	q_t      weight_mem   [gscc_pkg::CHANNELS * gscc_pkg::TAPS];
	bit      weight_known [gscc_pkg::CHANNELS * gscc_pkg::TAPS];
	q_t      gated_hist   [gscc_pkg::SLOTS * gscc_pkg::CHANNELS][gscc_pkg::HIST_DEPTH];
	result_t pending_results [$];
	int      failures;

	function new();
		taps_reg = gscc_pkg::TAPS_RESET;
		failures = 0;
		foreach (weight_known[i])
			weight_known[i] = 1'b0;
		foreach (gated_hist[r, a])
			gated_hist[r][a] = '0;
	endfunction

	// A setting of 0 behaves as one tap, anything above TAPS as TAPS.
	function int active_taps();
		int n;
		n = int'(taps_reg);
		if (n < 1)
			n = 1;
		if (n > gscc_pkg::TAPS)
			n = gscc_pkg::TAPS;
		return n;
	endfunction

	// Floor of (v + half) / 2^s, i.e. rounding half up.
	function longint round_q(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function q_t clip16(longint v, inout bit flag);
		if (v > 32767) begin
			flag = 1'b1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			flag = 1'b1;
			return 16'sh8000;
		end
		return q_t'(v);
	endfunction

	function void note_item(item_t it);
		int n, row, base, age, k, a;
		longint conv;
		q_t gb, gc, xv, p;
		bit clip;
		result_t r;
		base = int'(it.channel) * gscc_pkg::TAPS;
		if (it.cmd == gscc_pkg::CMD_WEIGHT) begin
			if (int'(it.tap) < gscc_pkg::TAPS) begin
				weight_mem[base + int'(it.tap)] = it.weight_value;
				weight_known[base + int'(it.tap)] = 1'b1;
			end
			return;
		end
		n = active_taps();
		row = int'(it.slot) * gscc_pkg::CHANNELS + int'(it.channel);
		gb = it.gate_b;
		gc = it.gate_c;
		xv = it.x;
		clip = 1'b0;
		p = clip16(round_q(longint'(gb) * longint'(xv), gscc_pkg::P_SHIFT), clip);
		// A sequence start sees an empty history.
		if (it.start_req) begin
			for (a = 0; a < gscc_pkg::HIST_DEPTH; a++)
				gated_hist[row][a] = '0;
		end
		// The highest used tap weights the newest gated sample.
		conv = longint'(p) * longint'(weight_mem[base + n - 1]);
		for (k = 0; k < n - 1; k++) begin
			age = n - 1 - k;
			conv += longint'(gated_hist[row][age - 1]) * longint'(weight_mem[base + k]);
		end
		r.y = clip16(round_q(longint'(gc) * conv, gscc_pkg::Y_SHIFT), clip);
		r.slot = it.slot;
		r.channel = it.channel;
		r.saturated = clip;
		pending_results.push_back(r);
		for (a = gscc_pkg::HIST_DEPTH - 1; a > 0; a--)
			gated_hist[row][a] = gated_hist[row][a - 1];
		gated_hist[row][0] = p;
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("ERROR: unexpected result y=%0d slot=%0d channel=%0d saturated=%0b",
					$signed(got.y), got.slot, got.channel, got.saturated);
			return;
		end
		want = pending_results.pop_front();
		if (got.y !== want.y || got.slot !== want.slot || got.channel !== want.channel ||
				got.saturated !== want.saturated) begin
			failures++;
			if (failures <= 10)
				$display({"ERROR: expected y=%0d slot=%0d channel=%0d saturated=%0b,",
					" got y=%0d slot=%0d channel=%0d saturated=%0b"},
					$signed(want.y), want.slot, want.channel, want.saturated,
					$signed(got.y), got.slot, got.channel, got.saturated);
		end
	endfunction

	function void finish_check();
		if (pending_results.size() != 0) begin
			failures += pending_results.size();
			$display("ERROR: %0d expected results never arrived", pending_results.size());
		end
	endfunction
endclass

module tb;
	import gscc_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 11;
	// The slowest correct run stays well under this limit, clearing pass included.
	localparam int CYCLE_LIMIT  = 400000;
	// Extra wait after the last result, for any item still in the engine.
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 106;
	localparam logic [PADDR_W-1:0] TAPS_ADDR = PADDR_W'(4 * REG_TAPS_IN_USE);

	// Clock, reset and configuration port
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	// Item channel
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_DATA;
	logic [SLOT_W-1:0] slot = '0;
	logic [CH_W-1:0] channel = '0;
	logic [TAP_FW-1:0] tap = '0;
	logic start_req = 1'b0;
	logic signed [DATA_W-1:0] gate_b = '0;
	logic signed [DATA_W-1:0] gate_c = '0;
	logic signed [DATA_W-1:0] x = '0;
	logic signed [DATA_W-1:0] weight_value = '0;

	// Result channel
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] y;
	logic [SLOT_W-1:0] out_slot;
	logic [CH_W-1:0] out_channel;
	logic saturated;

	// Percentage chance of an idle burst before each item on the sending
	// side; the receiving side stalls at a third of that rate per cycle.
	int idle_pct = 20;
	int stall_left = 0;
	int cycle_count = 0;

	// taps_in_use for each random phase: the extremes and the out-of-range
	// settings are all visited, and the last phase runs without idling.
	int taps_plan [PHASES] = '{4, 0, 7, 1, 5, 2, 6, 3};
	int idle_plan [PHASES] = '{25, 10, 40, 0, 20, 30, 10, 0};

	gated_conv_tracker tracker = new();

	gated_short_causal_conv_top u_top (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_valid, .in_ready, .cmd, .slot, .channel, .tap, .start_req,
		.gate_b, .gate_c, .x, .weight_value,
		.out_valid, .out_ready, .y, .out_slot, .out_channel, .saturated
	);

	always #CLK_HALF clk = ~clk;

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** gated_short_causal_conv_top: FAILED **");
			$finish;
		end
	end

	// Receiver: out_ready drops in bursts of random length. Outputs are
	// sampled at the edge, before any of this edge's updates take effect.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_pct > 0 && $urandom_range(0, 299) < idle_pct) begin
			stall_left <= $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.y = y;
			seen.slot = out_slot;
			seen.channel = out_channel;
			seen.saturated = saturated;
			tracker.check_result(seen);
		end
	end

	// Writes taps_in_use through a setup and an access phase. The upper
	// bits of the write data are random, as only the low bits are kept.
	// Called at a rising edge; returns at the edge that writes the register.
	task automatic write_taps(input logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[CFG_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TAPS_ADDR;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.taps_reg = value;
	endtask

	// Offers one item, possibly after an idle burst, and returns at the edge
	// that accepts it, so that the next item can follow without a gap.
	task automatic push_item(input item_t it);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		slot <= it.slot;
		channel <= it.channel;
		tap <= it.tap;
		start_req <= it.start_req;
		gate_b <= it.gate_b;
		gate_c <= it.gate_c;
		x <= it.x;
		weight_value <= it.weight_value;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_item(it);
	endtask

	// Lowers valid and waits until every result is in and the engine has
	// had time to finish any weight item still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic item_t make_item(input logic c, input int s, input int ch,
			input int t, input logic st, input int gb, input int gc, input int xv,
			input int wv);
		item_t it;
		it.cmd = c;
		it.slot = SLOT_W'(s);
		it.channel = CH_W'(ch);
		it.tap = TAP_FW'(t);
		it.start_req = st;
		it.gate_b = DATA_W'(gb);
		it.gate_c = DATA_W'(gc);
		it.x = DATA_W'(xv);
		it.weight_value = DATA_W'(wv);
		return it;
	endfunction

	// Q4.12 values: the extremes, moderate values that rarely clip, and the
	// full range, which clips often.
	function automatic logic signed [DATA_W-1:0] pick_q();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3, 4, 5: return DATA_W'(int'($urandom_range(0, 16383)) - 8192);
			default: return DATA_W'($urandom());
		endcase
	endfunction

	function automatic item_t random_item(input logic c, input int ch);
		item_t it;
		it.cmd = c;
		it.slot = SLOT_W'($urandom_range(0, SLOTS - 1));
		it.channel = CH_W'(ch);
		it.tap = TAP_FW'($urandom_range(0, TAPS - 1));
		it.start_req = ($urandom_range(0, 7) == 0);
		it.gate_b = pick_q();
		it.gate_c = pick_q();
		it.x = pick_q();
		it.weight_value = pick_q();
		return it;
	endfunction

	// Most items are data samples on a small pool of channels, so that the
	// histories fill up; any tap weight that a sample would read and that
	// was never loaded is written first. The rest are weight rewrites.
	task automatic random_phase(input int count);
		int done, ch, t;
		logic [CH_W-1:0] pool [8];
		item_t it;
		foreach (pool[i])
			pool[i] = CH_W'($urandom());
		pool[0] = '0;
		pool[1] = '1;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 3) != 0)
				ch = int'(pool[$urandom_range(0, 7)]);
			else
				ch = $urandom_range(0, CHANNELS - 1);
			if ($urandom_range(0, 99) < 75) begin
				for (t = 0; t < tracker.active_taps(); t++) begin
					if (!tracker.weight_known[ch * TAPS + t]) begin
						it = random_item(CMD_WEIGHT, ch);
						it.tap = TAP_FW'(t);
						push_item(it);
						done++;
					end
				end
				push_item(random_item(CMD_DATA, ch));
			end else begin
				push_item(random_item(CMD_WEIGHT, ch));
			end
			done++;
		end
	endtask

	initial begin
		item_t plan [$];
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset setting of three taps. Channel 0 gets
		// weights of full scale, negative full scale and unity on the newest
		// tap; channel 255 gets unity on all used taps. In some items the fields
		// that an item of the other kind ignores are set to their extremes.
		plan.push_back(make_item(CMD_WEIGHT, 0, 0, 0, 1'b0, 0, 0, 0, 32767));
		plan.push_back(make_item(CMD_WEIGHT, 0, 0, 1, 1'b0, 0, 0, 0, -32768));
		plan.push_back(make_item(CMD_WEIGHT, 0, 0, 2, 1'b0, 0, 0, 0, 4096));
		plan.push_back(make_item(CMD_WEIGHT, 0, 0, 3, 1'b1, -32768, 32767, -32768, -1));
		plan.push_back(make_item(CMD_WEIGHT, 3, 255, 0, 1'b0, 0, 0, 0, 4096));
		plan.push_back(make_item(CMD_WEIGHT, 3, 255, 1, 1'b0, 0, 0, 0, 4096));
		plan.push_back(make_item(CMD_WEIGHT, 3, 255, 2, 1'b0, 0, 0, 0, 4096));
		plan.push_back(make_item(CMD_WEIGHT, 3, 255, 3, 1'b1, 32767, -32768, 32767, 32767));
		// Unity through the newest tap at a sequence start.
		plan.push_back(make_item(CMD_DATA, 0, 0, 3, 1'b1, 4096, 4096, 4096, -32768));
		// Gated input clipped high, then low.
		plan.push_back(make_item(CMD_DATA, 0, 0, 0, 1'b0, -32768, 4096, -32768, 0));
		plan.push_back(make_item(CMD_DATA, 0, 0, 0, 1'b0, -32768, 4096, 32767, 0));
		// Exactly half a step rounds up, for both signs.
		plan.push_back(make_item(CMD_DATA, 0, 0, 0, 1'b0, 1, 32767, 2048, 0));
		plan.push_back(make_item(CMD_DATA, 0, 0, 0, 1'b0, -1, -32768, 2048, 0));
		plan.push_back(make_item(CMD_DATA, 0, 0, 0, 1'b0, 12345, -32768, -2222, 0));
		// Sequence start in the middle of a filled history.
		plan.push_back(make_item(CMD_DATA, 0, 0, 0, 1'b1, 4096, 4096, 8192, 0));
		// Same channel in a slot never used: history starts empty.
		plan.push_back(make_item(CMD_DATA, 1, 0, 0, 1'b0, 4096, -4096, 4096, 0));
		// Result clipped high and low on the top channel and slot.
		plan.push_back(make_item(CMD_DATA, 3, 255, 0, 1'b1, 32767, 32767, 32767, 0));
		plan.push_back(make_item(CMD_DATA, 3, 255, 0, 1'b0, -32768, -32768, 1, 0));
		plan.push_back(make_item(CMD_DATA, 3, 255, 0, 1'b0, 4096, 32767, -32768, 0));
		plan.push_back(make_item(CMD_DATA, 3, 255, 0, 1'b0, 32767, -32768, -32768, 0));
		// A product far below one step rounds to zero.
		plan.push_back(make_item(CMD_DATA, 2, 255, 2, 1'b0, 1, 1, 1, 32767));
		foreach (plan[i])
			push_item(plan[i]);

		// Random phases, each at its own tap setting, written while idle.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_taps(CFG_W'(taps_plan[ph]));
			idle_pct = idle_plan[ph];
			random_phase(PHASE_ITEMS);
		end
		drain();

		tracker.finish_check();
		if (tracker.failures == 0)
			$display("** gated_short_causal_conv_top: PASSED **");
		else
			$display("** gated_short_causal_conv_top: FAILED **");
		$finish;
	end

endmodule
